### sv/pav_pkg.sv
// Package for the persistent array versions block: sizes, field layout,
// command and state codes, link record and the span clamp. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pav_pkg;

	localparam int POSITIONS    = 1024;
	localparam int MAX_VERSIONS = 1024;
	localparam int POOL_NODES   = 32768;
	localparam int VALUE_BITS   = 32;

	localparam int POS_W   = $clog2(POSITIONS);
	localparam int SPAN_W  = POS_W + 1;
	localparam int VER_W   = $clog2(MAX_VERSIONS + 1);
	localparam int ROOT_D  = MAX_VERSIONS + 1;
	localparam int ROOT_AW = $clog2(ROOT_D);
	localparam int NODE_W  = $clog2(POOL_NODES);
	localparam int CNT_W   = NODE_W + 1;

	localparam int SPAN_CAP = (POOL_NODES + 1) / 2;
	localparam int SPAN_MAX = (POSITIONS < SPAN_CAP) ? POSITIONS : SPAN_CAP;

	localparam int CMD_W    = 2;
	localparam int IN_VER_W = 11;
	localparam int IN_POS_W = 10;
	localparam int IN_VAL_W = 32;
	localparam int CFG_W    = 11;
	localparam int OUT_RD_W = 32;
	localparam int OUT_NV_W = 11;

	localparam int S_VER_LO = 0;
	localparam int S_POS_LO = S_VER_LO + IN_VER_W;
	localparam int S_VAL_LO = S_POS_LO + IN_POS_W;
	localparam int S_BITS   = S_VAL_LO + IN_VAL_W;
	localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
	localparam int M_BITS   = OUT_RD_W + OUT_NV_W;
	localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_WALK,
		ST_READ,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} link_t;

	function automatic logic [SPAN_W-1:0] clamp_span(input logic [CFG_W-1:0] v);
		logic [SPAN_W-1:0] r;
		if (v == '0) begin
			r = SPAN_W'(1);
		end else if (int'(v) > SPAN_MAX) begin
			r = SPAN_W'(SPAN_MAX);
		end else begin
			r = SPAN_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/persistent_array_versions_top.sv
// Top level of the persistent array versions block: sequencer, tree walk
// and commit logic. Depends on pav_pkg and pav_ram.
//
// Usage: a versioned array of up to 1024 values kept as a persistent
// segment tree. One beat on the slave stream (s_tuser = command) gives one
// beat on the master stream. Init writes a leaf of version 0, update copies
// the root-to-leaf path into new pool nodes and records a new version, query
// reads a position and records a version equal to the source.
// An item passes from the root state through the walk (and a read state for
// a query) to the finish state: the walk visits one tree level per cycle
// through the node link memory, whose read address comes from the link read
// in the cycle before. A rejected item goes from idle straight to the finish
// state. The next beat is accepted at the earliest at the edge where the
// result can first be taken.
// Version-0 links are computed from the node range, so reset and a write to
// positions_in_use take effect at once: no memory sweep, version count zero.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register while the next item is accepted; if the receiver still
// holds it when the next item finishes, the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
module persistent_array_versions_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pav_pkg::CFG_W-1:0]     cfg_wdata,   // positions_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pav_pkg::S_DATA_W-1:0]  s_tdata,     // version, position, value
	input  logic [pav_pkg::CMD_W-1:0]     s_tuser,     // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pav_pkg::M_DATA_W-1:0]  m_tdata,     // read_value, new_version
	output logic                          m_tuser      // error
);
	import pav_pkg::*;

	state_t state_q, state_d;

	logic [SPAN_W-1:0]     span_q;
	logic [CNT_W-1:0]      v0size_q;
	logic [VER_W-1:0]      ver_cnt_q;
	logic [CNT_W-1:0]      node_cnt_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [IN_VER_W-1:0]   ver_q;
	logic [IN_POS_W-1:0]   pos_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  err_q;
	logic [OUT_RD_W-1:0]   rd_q;
	logic [OUT_NV_W-1:0]   made_q;
	logic [NODE_W-1:0]     cur_q;
	logic [NODE_W-1:0]     root_q;
	logic [POS_W-1:0]      lo_q, hi_q;
	logic [CNT_W-1:0]      nn_q;

	logic                  m_valid_q;
	logic [OUT_RD_W-1:0]   m_rd_q;
	logic [OUT_NV_W-1:0]   m_nv_q;
	logic                  m_err_q;

	logic [CMD_W-1:0]      in_cmd;
	logic [IN_VER_W-1:0]   in_ver;
	logic [IN_POS_W-1:0]   in_pos;
	logic [IN_VAL_W-1:0]   in_val;
	logic                  in_bad;
	logic                  accept;

	logic [NODE_W-1:0]     root_rd;
	logic [NODE_W-1:0]     root_node;
	logic                  root_we;
	logic [ROOT_AW-1:0]    root_raddr;
	logic [ROOT_AW-1:0]    root_waddr;
	logic [NODE_W-1:0]     root_wdata;

	link_t                 link_rd;
	link_t                 links;
	link_t                 link_new;
	logic                  link_we;
	logic [NODE_W-1:0]     link_raddr;

	logic [VALUE_BITS-1:0] val_rd;
	logic                  val_we;
	logic [NODE_W-1:0]     val_waddr;

	logic [POS_W-1:0]      mid;
	logic                  is_leaf;
	logic                  go_left;
	logic                  is_v0;
	logic                  pool_ok;
	logic [NODE_W-1:0]     half;
	logic [NODE_W-1:0]     child;
	logic [NODE_W-1:0]     nn_next;
	logic                  commit;
	logic                  out_free;

	assign in_cmd = s_tuser;
	assign in_ver = s_tdata[S_VER_LO +: IN_VER_W];
	assign in_pos = s_tdata[S_POS_LO +: IN_POS_W];
	assign in_val = s_tdata[S_VAL_LO +: IN_VAL_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_bad = 1'b0;
		if (in_cmd != CMD_INIT && in_cmd != CMD_UPDATE && in_cmd != CMD_QUERY) begin
			in_bad = 1'b1;
		end else if (int'(in_pos) >= int'(span_q)) begin
			in_bad = 1'b1;
		end else if (in_cmd != CMD_INIT) begin
			in_bad = (int'(in_ver) > int'(ver_cnt_q)) || (int'(ver_cnt_q) >= MAX_VERSIONS);
		end
	end

	// tree step
	assign mid      = POS_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign is_leaf  = (lo_q == hi_q);
	assign go_left  = (POS_W'(pos_q) <= mid);
	assign is_v0    = ({1'b0, cur_q} < v0size_q);
	assign pool_ok  = (nn_q < CNT_W'(POOL_NODES));
	assign half     = NODE_W'(mid - lo_q) + NODE_W'(1);
	assign nn_next  = NODE_W'(nn_q + CNT_W'(1));

	always_comb begin
		if (is_v0) begin
			links.left  = cur_q + NODE_W'(1);
			links.right = cur_q + (half << 1);
		end else begin
			links = link_rd;
		end
		child    = go_left ? links.left : links.right;
		link_new = links;
		if (go_left) begin
			link_new.left = nn_next;
		end else begin
			link_new.right = nn_next;
		end
	end

	assign root_node  = (cmd_q == CMD_INIT || ver_q == '0) ? '0 : root_rd;
	assign root_raddr = ROOT_AW'(in_ver);
	assign root_waddr = ROOT_AW'(ver_cnt_q + VER_W'(1));
	assign root_wdata = (cmd_q == CMD_UPDATE) ? root_q : root_q;
	assign link_raddr = (state_q == ST_ROOT) ? root_node : child;

	assign link_we  = (state_q == ST_WALK) && (cmd_q == CMD_UPDATE) && !is_leaf && pool_ok;
	assign val_we   = (state_q == ST_WALK) && is_leaf &&
		((cmd_q == CMD_INIT) || ((cmd_q == CMD_UPDATE) && pool_ok));
	assign val_waddr = (cmd_q == CMD_INIT) ? cur_q : NODE_W'(nn_q);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		root_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = in_bad ? ST_FIN : ST_ROOT;
				end
			end
			ST_ROOT: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (is_leaf) begin
					unique case (cmd_q)
						CMD_QUERY: state_d = ST_READ;
						CMD_UPDATE: begin
							state_d = ST_FIN;
							commit  = pool_ok;
							root_we = pool_ok;
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_FIN;
				commit  = 1'b1;
				root_we = 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q     <= SPAN_W'(SPAN_MAX);
			v0size_q   <= CNT_W'(2 * SPAN_MAX - 1);
			ver_cnt_q  <= '0;
			node_cnt_q <= CNT_W'(2 * SPAN_MAX - 1);
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				span_q     <= clamp_span(cfg_wdata);
				v0size_q   <= CNT_W'({clamp_span(cfg_wdata), 1'b0}) - CNT_W'(1);
				ver_cnt_q  <= '0;
				node_cnt_q <= CNT_W'({clamp_span(cfg_wdata), 1'b0}) - CNT_W'(1);
			end else if (commit) begin
				ver_cnt_q <= ver_cnt_q + VER_W'(1);
				if (cmd_q == CMD_UPDATE) begin
					node_cnt_q <= nn_q + CNT_W'(1);
				end
			end
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			ver_q  <= in_ver;
			pos_q  <= in_pos;
			val_q  <= VALUE_BITS'(in_val);
			err_q  <= in_bad;
			rd_q   <= '0;
			made_q <= '0;
		end
		unique case (state_q)
			ST_ROOT: begin
				lo_q  <= '0;
				hi_q  <= POS_W'(span_q - SPAN_W'(1));
				nn_q  <= node_cnt_q;
				if (cmd_q == CMD_UPDATE) begin
					root_q <= NODE_W'(node_cnt_q);
				end else begin
					root_q <= root_node;
				end
				cur_q <= root_node;
			end
			ST_WALK: begin
				if (is_leaf) begin
					if (cmd_q == CMD_UPDATE) begin
						if (pool_ok) begin
							made_q <= OUT_NV_W'(ver_cnt_q + VER_W'(1));
						end else begin
							err_q <= 1'b1;
						end
					end
				end else begin
					cur_q <= child;
					if (go_left) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + POS_W'(1);
					end
					if (cmd_q == CMD_UPDATE) begin
						nn_q <= nn_q + CNT_W'(1);
					end
				end
			end
			ST_READ: begin
				rd_q   <= OUT_RD_W'(val_rd);
				made_q <= OUT_NV_W'(ver_cnt_q + VER_W'(1));
			end
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			m_rd_q  <= rd_q;
			m_nv_q  <= made_q;
			m_err_q <= err_q;
		end
	end

	pav_ram #(.DEPTH(ROOT_D), .WIDTH(NODE_W)) u_root_ram (
		.clk   (clk),
		.we    (root_we),
		.waddr (root_waddr),
		.wdata (root_wdata),
		.raddr (root_raddr),
		.rdata (root_rd)
	);

	pav_ram #(.DEPTH(POOL_NODES), .WIDTH(2 * NODE_W)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (NODE_W'(nn_q)),
		.wdata (link_new),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	pav_ram #(.DEPTH(POOL_NODES), .WIDTH(VALUE_BITS)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (cur_q),
		.rdata (val_rd)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({m_nv_q, m_rd_q});
	assign m_tuser  = m_err_q;

	a_ver_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ver_cnt_q) <= MAX_VERSIONS)
		else $error("version count beyond table");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_cnt_q <= CNT_W'(POOL_NODES))
		else $error("node count beyond pool");

	a_pool_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> node_cnt_q >= $past(node_cnt_q))
		else $error("node count fell without a rebuild");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_err_q |-> m_nv_q == '0 && m_rd_q == '0)
		else $error("error result carries data");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> lo_q <= hi_q && int'(hi_q) < int'(span_q))
		else $error("walk range broken");
endmodule
`default_nettype wire

### sv/pav_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pav_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for persistent_array_versions_top: an in-bench tree model predicts
// every result beat. Stream traffic runs across several array lengths with random stalls.
// Depends on pav_pkg and the persistent_array_versions_top RTL.
`timescale 1ns / 1ps
module testbench;
	import pav_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOT_DEPTH = 24;

	typedef struct packed {
		logic [OUT_RD_W-1:0] rd;
		logic [OUT_NV_W-1:0] nv;
		logic                err;
	} vers_result_t;

	class version_tree_board;
		logic [VALUE_BITS-1:0] leaf_value [POOL_NODES];
		bit                    written    [POOL_NODES];
		logic [NODE_W-1:0]     kid_left   [POOL_NODES];
		logic [NODE_W-1:0]     kid_right  [POOL_NODES];
		logic [NODE_W-1:0]     root_of    [ROOT_D];
		int unsigned           span;
		int unsigned           versions;
		int unsigned           node_count;
		vers_result_t          awaited_results [$];
		int                    fails, accepted, results, updates, queries, errors, table_fills;

		function void rebuild(input logic [CFG_W-1:0] cfg);
			int unsigned s_lo [64];
			int unsigned s_hi [64];
			int unsigned s_up [64];
			bit          s_rt [64];
			int          sp;
			int unsigned lo, hi, up, me, mid;
			bit          rt;
			span = (cfg == '0) ? 1 : int'(cfg);
			if (span > SPAN_MAX) span = SPAN_MAX;
			foreach (written[k]) written[k] = 1'b0;
			versions = 0;
			node_count = 0;
			sp = 1;
			s_lo[0] = 0;
			s_hi[0] = span - 1;
			s_up[0] = 0;
			s_rt[0] = 1'b0;
			while (sp > 0) begin
				sp--;
				lo = s_lo[sp];
				hi = s_hi[sp];
				up = s_up[sp];
				rt = s_rt[sp];
				me = node_count;
				node_count++;
				kid_left[me] = '0;
				kid_right[me] = '0;
				if (me != 0) begin
					if (rt) kid_right[up] = NODE_W'(me);
					else kid_left[up] = NODE_W'(me);
				end
				if (lo != hi) begin
					mid = (lo + hi) >> 1;
					s_lo[sp] = mid + 1;
					s_hi[sp] = hi;
					s_up[sp] = me;
					s_rt[sp] = 1'b1;
					sp++;
					s_lo[sp] = lo;
					s_hi[sp] = mid;
					s_up[sp] = me;
					s_rt[sp] = 1'b0;
					sp++;
				end
			end
			root_of[0] = '0;
		endfunction

		function int unsigned leaf_at(input int unsigned root, input int unsigned pos);
			int unsigned lo, hi, mid, node;
			lo = 0;
			hi = span - 1;
			node = root;
			while (lo != hi) begin
				mid = (lo + hi) >> 1;
				if (pos <= mid) begin
					node = kid_left[node];
					hi = mid;
				end else begin
					node = kid_right[node];
					lo = mid + 1;
				end
			end
			return node;
		endfunction

		function int unsigned path_depth(input int unsigned pos);
			int unsigned lo, hi, mid, len;
			lo = 0;
			hi = span - 1;
			len = 1;
			while (lo != hi) begin
				mid = (lo + hi) >> 1;
				if (pos <= mid) hi = mid;
				else lo = mid + 1;
				len++;
			end
			return len;
		endfunction

		// A query is safe unless it would read a version-0 leaf that no init has set.
		function bit safe_to_read(input int unsigned ver, input int unsigned pos);
			if (pos >= span || ver > versions || versions >= MAX_VERSIONS) return 1'b1;
			return written[leaf_at(root_of[ver], pos)];
		endfunction

		function void note_item(input logic [CMD_W-1:0] cmd, input logic [IN_VER_W-1:0] ver,
				input logic [IN_POS_W-1:0] pos, input logic [IN_VAL_W-1:0] val);
			vers_result_t res;
			int unsigned  leaf, src, lo, hi, mid, nn, fresh;
			res = '0;
			accepted++;
			if (cmd == CMD_UNKNOWN || pos >= span) begin
				res.err = 1'b1;
			end else if (cmd == CMD_INIT) begin
				leaf = leaf_at(root_of[0], pos);
				leaf_value[leaf] = val;
				written[leaf] = 1'b1;
			end else if (ver > versions || versions >= MAX_VERSIONS) begin
				res.err = 1'b1;
			end else if (cmd == CMD_QUERY) begin
				leaf = leaf_at(root_of[ver], pos);
				res.rd = leaf_value[leaf];
				versions++;
				root_of[versions] = root_of[ver];
				res.nv = OUT_NV_W'(versions);
				queries++;
			end else if (path_depth(pos) > POOL_NODES - node_count) begin
				res.err = 1'b1;
			end else begin
				src = root_of[ver];
				lo = 0;
				hi = span - 1;
				fresh = node_count;
				while (1) begin
					nn = node_count;
					node_count++;
					kid_left[nn] = kid_left[src];
					kid_right[nn] = kid_right[src];
					leaf_value[nn] = leaf_value[src];
					written[nn] = written[src];
					if (lo == hi) begin
						leaf_value[nn] = val;
						written[nn] = 1'b1;
						break;
					end
					mid = (lo + hi) >> 1;
					if (pos <= mid) begin
						kid_left[nn] = NODE_W'(node_count);
						src = kid_left[src];
						hi = mid;
					end else begin
						kid_right[nn] = NODE_W'(node_count);
						src = kid_right[src];
						lo = mid + 1;
					end
				end
				versions++;
				root_of[versions] = NODE_W'(fresh);
				res.nv = OUT_NV_W'(versions);
				updates++;
			end
			if (res.err) errors++;
			if (!res.err && versions == MAX_VERSIONS && cmd != CMD_INIT) table_fills++;
			awaited_results.push_back(res);
		endfunction

		function void check_result(input logic [OUT_RD_W-1:0] rd, input logic [OUT_NV_W-1:0] nv,
				input logic err);
			vers_result_t want;
			results++;
			if (awaited_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%t: result beat with nothing outstanding: rd=%h ver=%0d err=%b",
						$realtime, rd, nv, err);
				return;
			end
			want = awaited_results.pop_front();
			if (rd !== want.rd || nv !== want.nv || err !== want.err) begin
				fails++;
				if (fails <= 10)
					$display("%t: beat %0d: want rd=%h ver=%0d err=%b, got rd=%h ver=%0d err=%b",
						$realtime, results, want.rd, want.nv, want.err, rd, nv, err);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	version_tree_board   sb;
	bit                  quiet;
	bit                  hold_request;
	int unsigned         cycle_count;
	int unsigned         hot_pos [$];
	int                  phases;

	persistent_array_versions_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[OUT_RD_W-1:0], m_tdata[OUT_RD_W +: OUT_NV_W], m_tuser);
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
				hold_request = 1'b0;
			end
			m_tready <= quiet || $urandom_range(99) >= 13;
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_VER_W-1:0] ver,
			input logic [IN_POS_W-1:0] pos, input logic [IN_VAL_W-1:0] val);
		logic [S_DATA_W-1:0] beat;
		beat = '0;
		beat[S_VER_LO +: IN_VER_W] = ver;
		beat[S_POS_LO +: IN_POS_W] = pos;
		beat[S_VAL_LO +: IN_VAL_W] = val;
		if (!quiet && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= beat;
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd, ver, pos, val);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] length);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= length;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.rebuild(length);
		hot_pos.delete();
		phases++;
	endtask

	function automatic logic [CMD_W-1:0] random_cmd();
		logic [CMD_W-1:0] pick;
		pick = CMD_W'($urandom_range(3));
		return pick;
	endfunction

	task automatic random_item(input bit fill_table);
		logic [CMD_W-1:0]    cmd;
		logic [IN_VER_W-1:0] ver;
		logic [IN_POS_W-1:0] pos;
		logic [IN_VAL_W-1:0] val;
		logic [IN_VAL_W-1:0] corner [4];
		int                  r;
		corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
		r = $urandom_range(99);
		val = $urandom;
		if ($urandom_range(15) == 0) val = corner[$urandom_range(3)];
		if ($urandom_range(9) < 7 && hot_pos.size() != 0)
			pos = IN_POS_W'(hot_pos[$urandom_range(hot_pos.size() - 1)]);
		else
			pos = IN_POS_W'($urandom_range(sb.span - 1));
		if ($urandom_range(3) == 0) ver = IN_VER_W'(sb.versions);
		else ver = IN_VER_W'($urandom_range(sb.versions));
		if (r < (fill_table ? 1 : 10)) begin
			cmd = random_cmd();
			ver = IN_VER_W'($urandom);
			pos = IN_POS_W'($urandom);
		end else if (r < (fill_table ? 4 : 32)) begin
			cmd = CMD_INIT;
		end else if (r < (fill_table ? 52 : 66)) begin
			cmd = CMD_UPDATE;
		end else begin
			cmd = CMD_QUERY;
		end
		if (cmd == CMD_QUERY && !sb.safe_to_read(ver, pos))
			cmd = fill_table ? CMD_UPDATE : CMD_INIT;
		if ((cmd == CMD_INIT || cmd == CMD_UPDATE) && pos < sb.span) begin
			if (hot_pos.size() < HOT_DEPTH) hot_pos.push_back(pos);
			else hot_pos[$urandom_range(HOT_DEPTH - 1)] = pos;
		end
		send_item(cmd, ver, pos, val);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] length, input int count, input bit fill_table);
		int k;
		int extra;
		write_length(length);
		k = 0;
		extra = 0;
		while (fill_table ? (sb.versions < MAX_VERSIONS || extra < 12) : k < count) begin
			if (k == 8) drain();
			if (k == 14) hold_request = 1'b1;
			quiet = fill_table && k >= 100 && k < 260;
			random_item(fill_table);
			if (sb.versions >= MAX_VERSIONS) extra++;
			k++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_INIT;
		quiet = 1'b0;
		hold_request = 1'b0;
		cycle_count = 0;
		phases = 1;
		sb = new();
		sb.rebuild(CFG_W'(POSITIONS));
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full-length array straight out of reset
		send_item(CMD_INIT, 0, 0, 32'h8000_0000);
		send_item(CMD_INIT, 0, 1023, 32'h7FFF_FFFF);
		send_item(CMD_INIT, 0, 511, 32'hFFFF_FFFF);
		send_item(CMD_INIT, 0, 512, 32'h0000_0000);
		send_item(CMD_QUERY, 0, 0, 32'h0);
		send_item(CMD_QUERY, 0, 1023, 32'h0);
		send_item(CMD_UPDATE, 0, 1023, 32'd5);
		send_item(CMD_QUERY, 3, 1023, 32'h0);
		send_item(CMD_QUERY, 2, 1023, 32'h0);
		send_item(CMD_INIT, 0, 0, 32'h1234_5678);
		send_item(CMD_QUERY, 3, 0, 32'h0);
		send_item(CMD_QUERY, 1, 0, 32'h0);
		send_item(CMD_UPDATE, 7, 511, 32'hDEAD_BEEF);
		send_item(CMD_QUERY, 8, 511, 32'h0);
		send_item(CMD_QUERY, 8, 512, 32'h0);
		send_item(CMD_QUERY, 11, 0, 32'h0);
		send_item(CMD_QUERY, 2047, 0, 32'h0);
		send_item(CMD_UPDATE, 1024, 0, 32'h0);
		send_item(CMD_UNKNOWN, 0, 0, 32'h0);
		send_item(CMD_INIT, 2047, 1, 32'h0000_0001);

		// short array: the last position and positions past the end
		write_length(3);
		send_item(CMD_INIT, 0, 2, 32'hA5A5_5A5A);
		send_item(CMD_INIT, 0, 3, 32'h1);
		send_item(CMD_UPDATE, 0, 3, 32'h2);
		send_item(CMD_QUERY, 0, 1023, 32'h0);
		send_item(CMD_UPDATE, 0, 2, 32'h3);

		run_phase(0, 10, 1'b0);
		run_phase(1, 10, 1'b0);
		run_phase(2, 10, 1'b0);
		run_phase(7, 10, 1'b0);
		run_phase(2047, 10, 1'b0);
		run_phase(CFG_W'($urandom_range(4, 1023)), 10, 1'b0);
		run_phase(700, 0, 1'b1);
		run_phase(1024, 20, 1'b0);

		drain();
		$display("covered %0d array lengths, %0d beats in, %0d beats out", phases, sb.accepted,
			sb.results);
		$display("%0d updates, %0d queries, %0d error beats, version table filled %0d time(s)",
			sb.updates, sb.queries, sb.errors, sb.table_fills);
		if (sb.fails == 0 && sb.awaited_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### files.f
sv/pav_pkg.sv
sv/pav_ram.sv
sv/persistent_array_versions_top.sv
dv/testbench.sv
